// ===== rtl/vnorm_pkg.sv =====
// ---------------------------------------------------------------------------
// vnorm_pkg
// Shared types and constants for the 3-D vector normalizer.
// ---------------------------------------------------------------------------
package vnorm_pkg;

  localparam int unsigned NUM_AXES = 3;

  typedef struct packed {
    logic valid;
    logic zero;
  } vn_ctrl_t;

endpackage

// ===== rtl/vnorm_if.sv =====
// ---------------------------------------------------------------------------
// vnorm_if
// Valid/ready channels carrying three signed components; the output one also carries a zero-length flag.
// ---------------------------------------------------------------------------
interface vnorm_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] comp_x;
  logic signed [W-1:0] comp_y;
  logic signed [W-1:0] comp_z;

  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vnorm_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] unit_x;
  logic signed [W-1:0] unit_y;
  logic signed [W-1:0] unit_z;
  logic                zero_length;

  modport source (output valid, unit_x, unit_y, unit_z, zero_length, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, zero_length, output ready);
endinterface

// ===== rtl/vnorm_cell.sv =====
// ---------------------------------------------------------------------------
// vnorm_cell
// One bit decision of the rounded ratio search for three axes.
// Tests candidate q = acc | bit: (2q-1)^2 * S <= 4 c^2 2^(2F).
// Carries q^2 * S and q * S along the chain, so the test is shifts and adds.
// ---------------------------------------------------------------------------
module vnorm_cell #(
  parameter int QW   = 15,
  parameter int SW   = 34,
  parameter int RW   = 62,
  parameter int BIT  = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       stall,
  input  logic [SW-1:0]              s_in,
  input  logic [3*RW-1:0]            r_in,
  input  logic [3*(2*QW+SW)-1:0]     a_in,
  input  logic [3*(QW+SW)-1:0]       b_in,
  input  logic [3*QW-1:0]            q_in,
  input  logic [2:0]                 neg_in,
  input  vnorm_pkg::vn_ctrl_t        ctrl_in,
  output logic [SW-1:0]              s_out,
  output logic [3*RW-1:0]            r_out,
  output logic [3*(2*QW+SW)-1:0]     a_out,
  output logic [3*(QW+SW)-1:0]       b_out,
  output logic [3*QW-1:0]            q_out,
  output logic [2:0]                 neg_out,
  output vnorm_pkg::vn_ctrl_t        ctrl_out
);

  localparam int AW = 2 * QW + SW;
  localparam int BW = QW + SW;
  localparam int PW = AW + 2;

  logic [3*QW-1:0]     q_nxt;
  logic [3*AW-1:0]     a_nxt;
  logic [3*BW-1:0]     b_nxt;
  logic [SW-1:0]       s_r;
  logic [3*RW-1:0]     r_r;
  logic [3*AW-1:0]     a_r;
  logic [3*BW-1:0]     b_r;
  logic [3*QW-1:0]     q_r;
  logic [2:0]          neg_r;
  vnorm_pkg::vn_ctrl_t ctrl_r;

  always_comb begin
    logic [AW-1:0] ca;
    logic [BW-1:0] cb;
    logic [PW-1:0] lhs;
    q_nxt = q_in;
    a_nxt = a_in;
    b_nxt = b_in;
    for (int a = 0; a < int'(vnorm_pkg::NUM_AXES); a++) begin
      ca  = a_in[a*AW +: AW] + (AW'(b_in[a*BW +: BW]) << (BIT + 1)) +
            (AW'(s_in) << (2 * BIT));
      cb  = b_in[a*BW +: BW] + (BW'(s_in) << BIT);
      lhs = (PW'(ca) << 2) - (PW'(cb) << 2) + PW'(s_in);
      if (lhs <= PW'(r_in[a*RW +: RW])) begin
        q_nxt[a*QW +: QW] = q_in[a*QW +: QW] | (QW'(1) << BIT);
        a_nxt[a*AW +: AW] = ca;
        b_nxt[a*BW +: BW] = cb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else if (!stall) begin
      ctrl_r.valid <= ctrl_in.valid;
    end
    if (!stall) begin
      s_r         <= s_in;
      r_r         <= r_in;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      q_r         <= q_nxt;
      neg_r       <= neg_in;
      ctrl_r.zero <= ctrl_in.zero;
    end
  end

  assign s_out    = s_r;
  assign r_out    = r_r;
  assign a_out    = a_r;
  assign b_out    = b_r;
  assign q_out    = q_r;
  assign neg_out  = neg_r;
  assign ctrl_out = ctrl_r;

endmodule

// ===== rtl/vector3_normalizer.sv =====
// ---------------------------------------------------------------------------
// vector3_normalizer
// Scales a 3-D vector to unit length, rounding each component to nearest.
//
//  channel | dir | payload
//  in_     | in  | comp_x, comp_y, comp_z (signed IN_WIDTH)
//  out_    | out | unit_x, unit_y, unit_z (signed OUT_FRAC_BITS+2), zero_length
//
// One vector per cycle while the output is not stalled: one square stage,
// one sum stage, then one cell per magnitude bit of the result, MSB first.
// The whole chain advances together and holds while the output is stalled.
// Reset clears the valid bits of every stage.
// ---------------------------------------------------------------------------
module vector3_normalizer #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  vnorm_in_if.sink    in_ch,
  vnorm_out_if.source out_ch
);

  localparam int MW = IN_WIDTH;
  localparam int SW = 2 * MW + 2;
  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int RW = 2 * MW + 2 * OUT_FRAC_BITS + 2;
  localparam int NC = QW;
  localparam int OW = OUT_FRAC_BITS + 2;
  localparam int AW = 2 * QW + SW;
  localparam int BW = QW + SW;

  logic stall;
  assign stall       = out_ch.valid && !out_ch.ready;
  assign in_ch.ready = !stall;

  // stage 1: magnitudes and squares
  logic [MW-1:0]       mag [3];
  logic [2:0]          neg_nxt;
  logic [3*RW-1:0]     sq_r;
  logic [2:0]          neg_r;
  logic                v1_r;

  always_comb begin
    neg_nxt[0] = in_ch.comp_x[MW-1];
    neg_nxt[1] = in_ch.comp_y[MW-1];
    neg_nxt[2] = in_ch.comp_z[MW-1];
    mag[0] = neg_nxt[0] ? MW'(-in_ch.comp_x) : MW'(in_ch.comp_x);
    mag[1] = neg_nxt[1] ? MW'(-in_ch.comp_y) : MW'(in_ch.comp_y);
    mag[2] = neg_nxt[2] ? MW'(-in_ch.comp_z) : MW'(in_ch.comp_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (!stall) begin
      v1_r <= in_ch.valid;
    end
    if (!stall) begin
      for (int a = 0; a < int'(vnorm_pkg::NUM_AXES); a++)
        sq_r[a*RW +: RW] <= RW'((2*MW)'(mag[a]) * (2*MW)'(mag[a]));
      neg_r <= neg_nxt;
    end
  end

  // stage 2: sum of squares and scaled targets
  logic [SW-1:0]       s2_r;
  logic [3*RW-1:0]     r2_r;
  logic [2:0]          neg2_r;
  vnorm_pkg::vn_ctrl_t c2_r;
  logic [SW-1:0]       s_sum;

  assign s_sum = SW'(sq_r[0 +: RW]) + SW'(sq_r[RW +: RW]) + SW'(sq_r[2*RW +: RW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r.valid <= 1'b0;
    end else if (!stall) begin
      c2_r.valid <= v1_r;
    end
    if (!stall) begin
      c2_r.zero <= (s_sum == '0);
      s2_r      <= (s_sum == '0) ? SW'(1) : s_sum;
      for (int a = 0; a < int'(vnorm_pkg::NUM_AXES); a++)
        r2_r[a*RW +: RW] <= sq_r[a*RW +: RW] << (2 * OUT_FRAC_BITS + 2);
      neg2_r <= neg_r;
    end
  end

  // chain of cells
  logic [SW-1:0]       s_c   [NC+1];
  logic [3*RW-1:0]     r_c   [NC+1];
  logic [3*AW-1:0]     a_c   [NC+1];
  logic [3*BW-1:0]     b_c   [NC+1];
  logic [3*QW-1:0]     q_c   [NC+1];
  logic [2:0]          n_c   [NC+1];
  vnorm_pkg::vn_ctrl_t k_c   [NC+1];

  assign s_c[0]   = s2_r;
  assign r_c[0]   = r2_r;
  assign a_c[0]   = '0;
  assign b_c[0]   = '0;
  assign q_c[0]   = '0;
  assign n_c[0]   = neg2_r;
  assign k_c[0]   = c2_r;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    vnorm_cell #(
      .QW (QW), .SW (SW), .RW (RW), .BIT (QW - 1 - g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .stall    (stall),
      .s_in     (s_c[g]),
      .r_in     (r_c[g]),
      .a_in     (a_c[g]),
      .b_in     (b_c[g]),
      .q_in     (q_c[g]),
      .neg_in   (n_c[g]),
      .ctrl_in  (k_c[g]),
      .s_out    (s_c[g+1]),
      .r_out    (r_c[g+1]),
      .a_out    (a_c[g+1]),
      .b_out    (b_c[g+1]),
      .q_out    (q_c[g+1]),
      .neg_out  (n_c[g+1]),
      .ctrl_out (k_c[g+1])
    );
  end

  logic [OW-1:0] res [3];
  always_comb begin
    for (int a = 0; a < int'(vnorm_pkg::NUM_AXES); a++) begin
      res[a] = OW'(q_c[NC][a*QW +: QW]);
      if (k_c[NC].zero)
        res[a] = '0;
      else if (n_c[NC][a])
        res[a] = OW'(-res[a]);
    end
  end

  assign out_ch.valid       = k_c[NC].valid;
  assign out_ch.unit_x      = res[0];
  assign out_ch.unit_y      = res[1];
  assign out_ch.unit_z      = res[2];
  assign out_ch.zero_length = k_c[NC].zero;

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped under stall");
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_length |-> out_ch.unit_x == '0 &&
    out_ch.unit_y == '0 && out_ch.unit_z == '0)
    else $error("zero vector gave nonzero result");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
`endif

endmodule

// ===== dv/tb_vector3_normalizer.sv =====
// ---------------------------------------------------------------------------
// tb_vector3_normalizer
// Testbench for the 3-D vector normalizer. Directed corner vectors and then
// random ones are driven over the input channel. A scoreboard works out
// each expected unit vector by an exact round-to-nearest search and checks
// the results in order. Sender and receiver idle at random, in phases.
// ---------------------------------------------------------------------------
module tb_vector3_normalizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W   = 16;
  localparam int FRAC   = 14;
  localparam int OUT_W  = FRAC + 2;
  localparam int LAT    = FRAC + 3;
  localparam int LIMIT  = 400000;

  typedef struct {
    logic signed [OUT_W-1:0] ux;
    logic signed [OUT_W-1:0] uy;
    logic signed [OUT_W-1:0] uz;
    logic                    zl;
  } unit_vec_t;

  class norm_scoreboard;
    unit_vec_t pending[$];
    int        errors;

    function automatic logic [OUT_W-1:0] round_ratio(longint c, longint s);
      longint lo;
      longint hi;
      longint mid;
      logic [127:0] lhs;
      logic [127:0] rhs;
      lo  = 0;
      hi  = longint'(1) << FRAC;
      rhs = 128'(c * c) << (2 * FRAC + 2);
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        lhs = 128'((2 * mid - 1) * (2 * mid - 1)) * 128'(s);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return OUT_W'(lo);
    endfunction

    function automatic void note_input(logic signed [IN_W-1:0] x,
                                       logic signed [IN_W-1:0] y,
                                       logic signed [IN_W-1:0] z);
      longint    mx;
      longint    my;
      longint    mz;
      longint    s;
      unit_vec_t u;
      mx = x < 0 ? -longint'(x) : longint'(x);
      my = y < 0 ? -longint'(y) : longint'(y);
      mz = z < 0 ? -longint'(z) : longint'(z);
      s  = mx * mx + my * my + mz * mz;
      if (s == 0) begin
        u = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
      end else begin
        u.ux = round_ratio(mx, s);
        u.uy = round_ratio(my, s);
        u.uz = round_ratio(mz, s);
        if (x < 0) u.ux = -u.ux;
        if (y < 0) u.uy = -u.uy;
        if (z < 0) u.uz = -u.uz;
        u.zl = 1'b0;
      end
      pending.push_back(u);
    endfunction

    function automatic void check_result(unit_vec_t act);
      unit_vec_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d zl=%0b",
                 $time, act.ux, act.uy, act.uz, act.zl);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (act.ux !== e.ux || act.uy !== e.uy || act.uz !== e.uz || act.zl !== e.zl) begin
        $display("%0t: mismatch exp x=%0d y=%0d z=%0d zl=%0b act x=%0d y=%0d z=%0d zl=%0b",
                 $time, e.ux, e.uy, e.uz, e.zl, act.ux, act.uy, act.uz, act.zl);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  bit   hold_off = 1'b0;

  vnorm_in_if  #(.W(IN_W))  in_ch ();
  vnorm_out_if #(.W(OUT_W)) out_ch ();

  vector3_normalizer #(.IN_WIDTH(IN_W), .OUT_FRAC_BITS(FRAC)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  norm_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_vector3_normalizer: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{ux: out_ch.unit_x, uy: out_ch.unit_y,
                        uz: out_ch.unit_z, zl: out_ch.zero_length});
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_vec(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                          logic signed [IN_W-1:0] z);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.comp_x <= x;
    in_ch.comp_y <= y;
    in_ch.comp_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(x, y, z);
  endtask

  function automatic logic [IN_W-1:0] rand_comp();
    case ($urandom_range(5))
      0:       return IN_W'($urandom_range(7)) - 16'sd3;
      1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return IN_W'($urandom());
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_vec(rand_comp(), rand_comp(), rand_comp());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.comp_x <= '0;
    in_ch.comp_y <= '0;
    in_ch.comp_z <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vec(16'sd0, 16'sd0, 16'sd0);
    send_vec(16'sh7fff, 16'sd0, 16'sd0);
    send_vec(16'sd0, -16'sd1, 16'sd0);
    send_vec(16'sd0, 16'sd0, 16'sh8000);
    send_vec(16'sh8000, 16'sh8000, 16'sh8000);
    send_vec(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vec(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_vec(16'sd1, 16'sd1, 16'sd0);
    send_vec(16'sd1, 16'sd1, 16'sd1);
    send_vec(16'sd3, 16'sd4, 16'sd0);
    send_vec(-16'sd3, 16'sd0, 16'sd4);
    send_vec(16'sd2, 16'sd1, 16'sd2);
    send_vec(16'sd1, 16'sd2, 16'sd2);
    send_vec(16'sh8000, 16'sd1, -16'sd1);
    send_vec(-16'sd1, -16'sd1, -16'sd1);
    send_vec(16'sh5555, 16'shaaaa, 16'sh0f0f);
    send_vec(16'sd0, 16'sd0, 16'sd1);
    send_vec(16'sd0, 16'sd0, 16'sd0);
    drain();

    send_random(200);
    send_idle = 49; send_random(180);
    drain();
    send_idle = 0; recv_stall = 49; send_random(180);
    send_idle = 34; recv_stall = 34; send_random(150);

    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_idle = 0;
        send_random(60);
      end
    join
    drain();
    send_idle = 0; recv_stall = 0; send_random(80);
    drain();

    repeat (LAT + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_vector3_normalizer: done, clean");
    else
      $display("tb_vector3_normalizer: done, errors");
    $finish;
  end
endmodule
